[rtl/lfxd_pkg.sv]
// shared constants and codes for the length framed xor deframer
package lfxd_pkg;

  localparam int unsigned LFXD_MAX_DATA = 32;

  localparam int unsigned HDR_BYTES = 4;

  // register map, selected by paddr[2]
  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_MAX_PAYLOAD  = 1'b1;

  localparam logic [7:0] START_MARKER_RST = 8'd170;
  localparam logic [5:0] MAX_PAYLOAD_RST  = 6'd32;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_LONG = 2'd1,
    STATUS_BAD_XOR  = 2'd2
  } status_t;

endpackage

[rtl/length_framed_xor_deframer_core.sv]
// length framed xor deframer: frame parser, payload store and result sequencer
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | s_tdata = rx_byte
//  m_      | out | m_tvalid / m_tready  | m_tdata, m_tuser, m_tlast
//  apb     | in  | psel/penable/pwrite  | paddr, pwdata, prdata
//
// a received byte is taken while the result register is empty
// a passing frame then emits its header and, per payload byte, one result after a
// store read step and a load step; each result waits in the result register until
// it is taken before the next store read; the single payload store read port sets this pace
// s_tready is low while the stored payload is being read out
// rst is synchronous; the payload store is not cleared, only bytes of the
// current frame are read back
module length_framed_xor_deframer_core
  import lfxd_pkg::*;
#(
  parameter int unsigned MAX_DATA = LFXD_MAX_DATA
) (
  input  logic        clk,
  input  logic        rst,
  // slave side stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // master side stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] command, [15:8] payload_length, [23:16] data_byte
  output logic [2:0]  m_tuser,   // [0] is_header, [2:1] status
  output logic        m_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam int unsigned CW = $clog2(MAX_DATA + 1);

  typedef enum logic [1:0] {
    ST_RECV,
    ST_WAIT,
    ST_FETCH,
    ST_LOAD
  } state_t;

  state_t      state;
  logic [7:0]  start_marker;
  logic [5:0]  max_payload;

  logic        in_frame;
  logic [8:0]  byte_count;
  logic [7:0]  frame_command;
  logic [7:0]  frame_length;
  logic [7:0]  received_check;
  logic [7:0]  running_xor;

  logic [7:0]  payload_store [MAX_DATA];
  logic [7:0]  rd_data;
  logic [CW-1:0] rd_idx;

  logic [7:0]  out_command;
  logic [7:0]  out_length;
  logic [7:0]  out_data;
  logic        out_header;
  status_t     out_status;
  logic        out_last;
  logic        out_valid;

  // per byte datapath
  logic        s_fire;
  logic        m_fire;
  logic        cfg_wr;
  logic [8:0]  count_next;
  logic [7:0]  length_next;
  logic [7:0]  check_next;
  logic [7:0]  xor_next;
  logic        is_payload;
  logic [8:0]  store_idx;
  logic        store_en;
  logic        frame_done;
  logic        too_long;
  logic        bad_xor;

  assign s_fire = s_tvalid && s_tready;
  assign m_fire = out_valid && m_tready;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign s_tready = (state == ST_RECV) && !out_valid;

  always_comb begin
    is_payload  = (byte_count >= 9'(HDR_BYTES));
    count_next  = byte_count + 9'd1;
    length_next = (byte_count == 9'd2) ? s_tdata : frame_length;
    check_next  = (byte_count == 9'd3) ? s_tdata : received_check;
    xor_next    = is_payload ? (running_xor ^ s_tdata) : running_xor;
    store_idx   = byte_count - 9'(HDR_BYTES);
    store_en    = s_fire && in_frame && is_payload && (store_idx < 9'(MAX_DATA));
    frame_done  = (count_next >= 9'(HDR_BYTES)) &&
                  (count_next >= (9'(HDR_BYTES) + {1'b0, length_next}));
    too_long    = (length_next > {2'b00, max_payload}) || (length_next > 8'(MAX_DATA));
    bad_xor     = (xor_next != check_next);
  end

  // payload store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (store_en) begin
      payload_store[store_idx[AW-1:0]] <= s_tdata;
    end
    if (state == ST_FETCH) begin
      rd_data <= payload_store[rd_idx[AW-1:0]];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RST;
      max_payload  <= MAX_PAYLOAD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_START_MARKER: start_marker <= pwdata[7:0];
        REG_MAX_PAYLOAD:  max_payload  <= pwdata[5:0];
        default:          ;
      endcase
    end
  end

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_START_MARKER: prdata = {24'd0, start_marker};
      REG_MAX_PAYLOAD:  prdata = {26'd0, max_payload};
      default:          prdata = 32'd0;
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_RECV;
      in_frame       <= 1'b0;
      byte_count     <= 9'd0;
      frame_command  <= 8'd0;
      frame_length   <= 8'd0;
      received_check <= 8'd0;
      running_xor    <= 8'd0;
      rd_idx         <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (m_fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_RECV: begin
          if (s_fire) begin
            if (!in_frame) begin
              if (s_tdata == start_marker) begin
                in_frame       <= 1'b1;
                byte_count     <= 9'd1;
                frame_command  <= 8'd0;
                frame_length   <= 8'd0;
                received_check <= 8'd0;
                running_xor    <= 8'd0;
              end
            end else begin
              if (byte_count == 9'd1) begin
                frame_command <= s_tdata;
              end
              frame_length   <= length_next;
              received_check <= check_next;
              if (frame_done) begin
                in_frame    <= 1'b0;
                byte_count  <= 9'd0;
                running_xor <= 8'd0;
                out_valid   <= 1'b1;
                out_header  <= 1'b1;
                out_command <= frame_command;
                out_length  <= length_next;
                out_data    <= 8'd0;
                rd_idx      <= '0;
                if (too_long) begin
                  out_status <= STATUS_TOO_LONG;
                  out_last   <= 1'b1;
                end else if (bad_xor) begin
                  out_status <= STATUS_BAD_XOR;
                  out_last   <= 1'b1;
                end else begin
                  out_status <= STATUS_OK;
                  out_last   <= (length_next == 8'd0);
                  if (length_next != 8'd0) begin
                    state <= ST_WAIT;
                  end
                end
              end else begin
                byte_count  <= count_next;
                running_xor <= xor_next;
              end
            end
          end
        end
        ST_WAIT: begin
          if (m_fire) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          out_valid   <= 1'b1;
          out_header  <= 1'b0;
          out_status  <= STATUS_OK;
          out_command <= 8'd0;
          out_length  <= 8'd0;
          out_data    <= rd_data;
          rd_idx      <= rd_idx + CW'(1);
          if ((8'(rd_idx) + 8'd1) == frame_length) begin
            out_last <= 1'b1;
            state    <= ST_RECV;
          end else begin
            out_last <= 1'b0;
            state    <= ST_WAIT;
          end
        end
        default: state <= ST_RECV;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_data, out_length, out_command};
  assign m_tuser  = {out_status, out_header};
  assign m_tlast  = out_last;

  // no byte is taken while payload results are pending
  a_no_rx_during_readout: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RECV) |-> !s_tready)
    else $error("byte accepted during payload readout");

  // a store read is always followed by loading the result register
  a_fetch_then_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |=> (state == ST_LOAD))
    else $error("store read not followed by load");

  // the readout index stays inside the frame
  a_idx_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |-> ((8'(rd_idx) < frame_length) && (rd_idx < CW'(MAX_DATA))))
    else $error("readout index beyond frame");

  // an error result is a header and ends the run
  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != STATUS_OK)) |-> (out_header && out_last))
    else $error("error result not a final header");

  // the load never overwrites a result still waiting
  a_load_into_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> !out_valid)
    else $error("result register overwritten");

endmodule

[tb/length_framed_xor_deframer_core_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the length framed xor deframer core
module length_framed_xor_deframer_core_tb;
  import lfxd_pkg::*;

  typedef struct packed {
    logic       is_header;
    status_t    status;
    logic [7:0] command;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
    logic       last;
  } frame_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [7:0] command, [15:8] payload_length, [23:16] data_byte
  logic [2:0]  m_tuser;   // [0] is_header, [2:1] status
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predicted deframer state and register copies
  logic [7:0]    cfg_marker  = START_MARKER_RST;
  logic [5:0]    cfg_max_len = MAX_PAYLOAD_RST;
  logic          in_frame    = 1'b0;
  logic [8:0]    byte_count  = '0;
  logic [7:0]    frame_cmd   = '0;
  logic [7:0]    frame_len   = '0;
  logic [7:0]    frame_sum   = '0;
  logic [7:0]    rx_xor      = '0;
  logic [7:0]    payload_mem [LFXD_MAX_DATA];
  frame_result_t expected_results [$];

  logic [7:0]    payload_buf [$];
  int unsigned   frame_bytes_sent = 0;
  int unsigned   error_count = 0;
  bit            steady = 1'b0;

  length_framed_xor_deframer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic string result_text(input frame_result_t r);
    return $sformatf("hdr=%0b st=%0d cmd=%02h len=%02h data=%02h last=%0b",
                     r.is_header, r.status, r.command, r.payload_length,
                     r.data_byte, r.last);
  endfunction

  // advance the frame parser by one received byte, queue what the frame emits
  function automatic void deframe_byte(input logic [7:0] b);
    frame_result_t r;
    int unsigned   i;
    if (!in_frame) begin
      if (b == cfg_marker) begin
        in_frame   = 1'b1;
        byte_count = 9'd1;
        frame_cmd  = '0;
        frame_len  = '0;
        frame_sum  = '0;
        rx_xor     = '0;
      end
      return;
    end
    case (byte_count)
      9'd1: frame_cmd = b;
      9'd2: frame_len = b;
      9'd3: frame_sum = b;
      default: begin
        // bytes past the store are counted but dropped
        if (byte_count - HDR_BYTES < LFXD_MAX_DATA)
          payload_mem[byte_count - HDR_BYTES] = b;
        rx_xor ^= b;
      end
    endcase
    byte_count = byte_count + 9'd1;
    if (byte_count < HDR_BYTES + frame_len)
      return;

    r = '0;
    r.is_header      = 1'b1;
    r.command        = frame_cmd;
    r.payload_length = frame_len;
    r.last           = 1'b1;
    if (frame_len > cfg_max_len || frame_len > LFXD_MAX_DATA) begin
      r.status = STATUS_TOO_LONG;
      expected_results.push_back(r);
    end else if (rx_xor != frame_sum) begin
      r.status = STATUS_BAD_XOR;
      expected_results.push_back(r);
    end else begin
      r.status = STATUS_OK;
      r.last   = (frame_len == 8'd0);
      expected_results.push_back(r);
      for (i = 0; i < frame_len; i++) begin
        r           = '0;
        r.data_byte = payload_mem[i];
        r.last      = (i + 1 == frame_len);
        expected_results.push_back(r);
      end
    end
    in_frame = 1'b0;
  endfunction

  // output check first, then the input transaction of the same edge
  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.is_header      = m_tuser[0];
        got.status         = status_t'(m_tuser[2:1]);
        got.command        = m_tdata[7:0];
        got.payload_length = m_tdata[15:8];
        got.data_byte      = m_tdata[23:16];
        got.last           = m_tlast;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %s",
                   $time, result_text(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            error_count++;
            $display("%0t: result mismatch, expected %s, actual %s",
                     $time, result_text(want), result_text(got));
          end
        end
      end
      if (s_tvalid && s_tready)
        deframe_byte(s_tdata);
    end
  end

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 18);
  end

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // payload comes from payload_buf; sum_flip != 0 corrupts the checksum
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                            input logic [7:0] sum_flip);
    logic [7:0] sum;
    sum = sum_flip;
    foreach (payload_buf[i]) sum ^= payload_buf[i];
    send_byte(cfg_marker);
    send_byte(cmd);
    send_byte(len);
    send_byte(sum);
    foreach (payload_buf[i]) send_byte(payload_buf[i]);
    frame_bytes_sent += 4 + payload_buf.size();
  endtask

  function automatic void fill_payload(input int unsigned n);
    payload_buf.delete();
    repeat (n)
      payload_buf.push_back(($urandom_range(7) == 0) ? cfg_marker : 8'($urandom));
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == cfg_marker);
    return b;
  endfunction

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (in_frame || expected_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // write a register, then read it back
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] readback_want;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_START_MARKER)
      cfg_marker = value[7:0];
    else
      cfg_max_len = value[5:0];
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback_want = (idx == REG_START_MARKER) ? {24'd0, cfg_marker} : {26'd0, cfg_max_len};
    if (prdata !== readback_want) begin
      error_count++;
      $display("%0t: register %0d readback mismatch, expected %08h, actual %08h",
               $time, idx, readback_want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_basic_frames();
    // bytes outside a frame are dropped
    send_byte(8'h00);
    send_byte(8'hFF);
    payload_buf.delete();
    send_frame(8'h00, 8'd0, 8'h00);
    send_frame(8'hFF, 8'd0, 8'h80);
    // marker value inside the payload is plain data
    payload_buf = '{8'hAA, 8'h00, 8'hFF};
    send_frame(8'h5A, 8'd3, 8'h00);
    payload_buf = '{8'h01, 8'h80};
    send_frame(8'hA5, 8'd2, 8'h01);
    wait_idle();
  endtask

  task automatic test_length_limits();
    steady = 1'b1;
    fill_payload(32);
    send_frame(8'h11, 8'd32, 8'h00);
    // too long wins over a bad checksum
    fill_payload(33);
    send_frame(8'h22, 8'd33, 8'h3C);
    fill_payload(64);
    send_frame(8'h33, 8'd64, 8'h00);
    write_reg(REG_MAX_PAYLOAD, 32'd0);
    payload_buf.delete();
    send_frame(8'h44, 8'd0, 8'h00);
    fill_payload(1);
    send_frame(8'h55, 8'd1, 8'h00);
    write_reg(REG_MAX_PAYLOAD, 32'd17);
    fill_payload(17);
    send_frame(8'h66, 8'd17, 8'h00);
    fill_payload(18);
    send_frame(8'h77, 8'd18, 8'h00);
    write_reg(REG_MAX_PAYLOAD, 32'd32);
    steady = 1'b0;
  endtask

  task automatic test_marker_values();
    logic [7:0] markers [3];
    markers = '{8'h00, 8'hFF, 8'($urandom)};
    foreach (markers[k]) begin
      write_reg(REG_START_MARKER, {24'd0, markers[k]});
      send_byte(noise_byte());
      fill_payload(4);
      send_frame(8'($urandom), 8'd4, 8'h00);
      fill_payload(2);
      send_frame(8'($urandom), 8'd2, 8'h40);
    end
    write_reg(REG_START_MARKER, {24'd0, START_MARKER_RST});
  endtask

  task automatic random_frame();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 3)) send_byte(noise_byte());
    end else if (pick < 76) begin
      // mostly short payloads, some up to the limit
      if (pick < 66)
        len = $urandom_range(0, (cfg_max_len < 8) ? cfg_max_len : 8);
      else
        len = $urandom_range(0, cfg_max_len);
      fill_payload(len);
      send_frame(8'($urandom), 8'(len), 8'h00);
    end else if (pick < 88) begin
      len = $urandom_range(0, cfg_max_len);
      fill_payload(len);
      send_frame(8'($urandom), 8'(len), 8'($urandom_range(1, 255)));
    end else begin
      len = cfg_max_len + $urandom_range(1, 6);
      fill_payload(len);
      send_frame(8'($urandom), 8'(len),
                 ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned first;
    for (phase = 0; phase < 4; phase++) begin
      write_reg(REG_START_MARKER, $urandom_range(255));
      case (phase)
        0:       write_reg(REG_MAX_PAYLOAD, 32'd32);
        1:       write_reg(REG_MAX_PAYLOAD, 32'd0);
        default: write_reg(REG_MAX_PAYLOAD, $urandom_range(1, 31));
      endcase
      // last phase runs without any idle cycles inserted by the bench
      steady = (phase == 3);
      first = frame_bytes_sent;
      while (frame_bytes_sent - first < 45) random_frame();
    end
    steady = 1'b0;
    wait_idle();
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    m_tready <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_frames();
    test_length_limits();
    test_marker_values();
    test_random_traffic();
    wait_idle();
    if (error_count == 0)
      $display("length_framed_xor_deframer_core regression: pass");
    else
      $display("length_framed_xor_deframer_core regression: fail");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("length_framed_xor_deframer_core regression: fail");
    $finish;
  end

endmodule
